[sv/plasma_ring_pixel_generator_assert.svh]
// Assertion macros shared by the texel generator.
`ifndef PLASMA_RING_PIXEL_GENERATOR_ASSERT_SVH
`define PLASMA_RING_PIXEL_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRPG_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define PRPG_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define PRPG_ASSERT_IMP(label, clk, rst, a, b)
`define PRPG_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

[sv/prpg_pkg.sv]
package prpg_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int DIM_W      = $clog2(MAX_DIM) + 1;
   localparam int PIX_W      = 12;
   localparam int TEXEL_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      MODE_SMOOTH = 3'd0,
      MODE_SHARP  = 3'd1,
      MODE_HORZ   = 3'd2,
      MODE_VERT   = 3'd3,
      MODE_DIAG   = 3'd4
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR   = 3'd6;

   localparam logic [DIM_W-1:0] RST_WIDTH     = 13'd256;
   localparam logic [DIM_W-1:0] RST_HEIGHT    = 13'd256;
   localparam logic [15:0]      RST_START     = 16'd16;
   localparam logic [15:0]      RST_GAIN      = 16'd4915;
   localparam logic [15:0]      RST_AMPLITUDE = 16'd23040;
   localparam logic [15:0]      RST_DIVISOR   = 16'd4096;

   // 2^32 / (2 pi), phase in units of 2^-32 turn
   localparam logic [29:0] PHASE_GAIN = 30'd683565276;
   localparam logic [16:0] HORNER_SEED = 17'd11;
   localparam logic [16:0] HORNER_COEF [0:3] = '{17'd307, 17'd5223, 17'd42334, 17'd102944};

   localparam int SQ_STAGES  = 11;
   localparam int DIV_STAGES = 26;
   localparam int GD_STAGES  = 4;

   localparam int RAD_LAT   = SQ_STAGES + 2;
   localparam int PH_LAT    = DIV_STAGES + 3;
   localparam int SIN_LAT   = 8;
   localparam int SHARP_LAT = 2;
   localparam int GRAD_LAT  = GD_STAGES + 2;
   localparam int PIPE_LAT  = RAD_LAT + PH_LAT + SIN_LAT;

   typedef struct packed {
      logic [42:0] rem;
      logic [21:0] root;
   } sq_type;

   typedef struct packed {
      logic [51:0] num;
      logic [15:0] rem;
      logic [31:0] q;
      logic        neg;
   } dv_type;

   typedef struct packed {
      logic [16:0] z;
      logic [16:0] z2;
      logic [16:0] t;
      logic        sgn;
   } hn_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [24:0] den;
      logic [7:0]  q;
      logic        sat;
   } gd_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] o;
      o = v;
      if (v == '0) o = 13'd1;
      else if (v > DIM_W'(MAX_DIM)) o = DIM_W'(MAX_DIM);
      return o;
   endfunction

   // one root bit of the restoring square root
   function automatic sq_type sqrt_step(input sq_type a, input int k);
      sq_type      o;
      logic [44:0] trial;
      o = a;
      trial = ({23'd0, a.root} << (k + 1)) | (45'd1 << (2 * k));
      if ({2'b00, a.rem} >= trial) begin
         o.rem  = a.rem - trial[42:0];
         o.root = a.root | (22'd1 << k);
      end
      return o;
   endfunction

   // one quotient bit of the long division by the wave divisor
   function automatic dv_type div_step(input dv_type a, input logic [15:0] dvs);
      dv_type      o;
      logic [16:0] r1;
      r1 = {a.rem, a.num[51]};
      o = a;
      o.num = {a.num[50:0], 1'b0};
      if (r1 >= {1'b0, dvs}) begin
         o.rem = 16'(r1 - {1'b0, dvs});
         o.q   = {a.q[30:0], 1'b1};
      end else begin
         o.rem = r1[15:0];
         o.q   = {a.q[30:0], 1'b0};
      end
      return o;
   endfunction

   function automatic hn_type horner_step(input hn_type a, input logic [16:0] coef);
      hn_type      o;
      logic [33:0] prod;
      prod = 34'(a.z2) * 34'(a.t);
      o = a;
      o.t = 17'(18'(coef) - prod[33:16]);
      return o;
   endfunction

   function automatic gd_type grad_step(input gd_type a, input int k);
      gd_type      o;
      logic [32:0] trial;
      o = a;
      trial = {8'd0, a.den} << k;
      if (a.rem >= trial) begin
         o.rem = a.rem - trial;
         o.q   = a.q | (8'd1 << k);
      end
      return o;
   endfunction

endpackage

[sv/prpg_radius.sv]
module prpg_radius (
   input  logic                            clock,
   input  logic                            en,
   input  logic [prpg_pkg::PIX_W-1:0]      pix_x,
   input  logic [prpg_pkg::PIX_W-1:0]      pix_y,
   input  logic [prpg_pkg::DIM_W-1:0]      width,
   input  logic [prpg_pkg::DIM_W-1:0]      height,
   input  logic [15:0]                     start,
   output logic [21:0]                     radius
);

   logic signed [14:0] dx, dy;
   logic signed [29:0] dx_sq, dy_sq;
   logic [25:0]        dx2_ff, dy2_ff;
   logic [27:0]        sum_in;
   prpg_pkg::sq_type   sq_ff [0:prpg_pkg::SQ_STAGES];

   // doubled offsets from the center, so half-pixel centers stay exact
   assign dx    = $signed({2'b00, pix_x, 1'b0}) - $signed({2'b00, width});
   assign dy    = $signed({2'b00, pix_y, 1'b0}) - $signed({2'b00, height});
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;
   assign sum_in = 28'({start, 2'b00}) + 28'(dx2_ff) + 28'(dy2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dx2_ff   <= dx_sq[25:0];
         dy2_ff   <= dy_sq[25:0];
         sq_ff[0] <= '{rem: {1'b0, sum_in, 14'd0}, root: '0};
      end
   end

   for (genvar j = 1; j <= prpg_pkg::SQ_STAGES; j++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j] <= prpg_pkg::sqrt_step(prpg_pkg::sqrt_step(sq_ff[j-1], 23 - 2 * j),
                                            22 - 2 * j);
         end
      end
   end

   assign radius = sq_ff[prpg_pkg::SQ_STAGES].root;

endmodule

[sv/prpg_phase.sv]
module prpg_phase (
   input  logic        clock,
   input  logic        en,
   input  logic [21:0] radius,
   input  logic [15:0] divisor,
   output logic [31:0] phase
);

   logic             neg_ff;
   logic [20:0]      mag_ff;
   logic             neg_in;
   logic [20:0]      mag_in;
   logic [51:0]      prod;
   prpg_pkg::dv_type dv_ff [0:prpg_pkg::DIV_STAGES];
   logic [31:0]      qc;
   logic [31:0]      phase_ff;

   assign neg_in = radius < 22'd1024;
   assign mag_in = neg_in ? 21'(22'd1024 - radius) : 21'(radius - 22'd1024);
   assign prod   = 52'(mag_ff) * 52'(prpg_pkg::PHASE_GAIN);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
         dv_ff[0] <= '{num: prod, rem: '0, q: '0, neg: neg_ff};
      end
   end

   for (genvar j = 1; j <= prpg_pkg::DIV_STAGES; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j] <= prpg_pkg::div_step(prpg_pkg::div_step(dv_ff[j-1], divisor), divisor);
         end
      end
   end

   // round toward minus infinity for negative distances, then wrap the turn
   assign qc = dv_ff[prpg_pkg::DIV_STAGES].q
             + {31'd0, dv_ff[prpg_pkg::DIV_STAGES].neg
                       && (dv_ff[prpg_pkg::DIV_STAGES].rem != '0)};

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= dv_ff[prpg_pkg::DIV_STAGES].neg ? (32'd0 - qc) : qc;
      end
   end

   assign phase = phase_ff;

endmodule

[sv/prpg_sine.sv]
module prpg_sine (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] phase,
   input  logic [15:0] amplitude,
   output logic [7:0]  texel
);

   logic [15:0]      f;
   logic [16:0]      z_in;
   logic [16:0]      z_ff;
   logic             sgn_ff;
   logic [33:0]      zz;
   prpg_pkg::hn_type hn_ff [0:4];
   logic [33:0]      zt;
   logic [17:0]      v;
   logic [15:0]      s;
   logic [15:0]      u_ff;
   logic [31:0]      pr;
   logic [7:0]       texel_ff;

   assign f    = phase[29:14];
   // mirror inside odd quadrants
   assign z_in = phase[30] ? 17'(17'h10000 - {1'b0, f}) : {1'b0, f};
   assign zz   = 34'(z_ff) * 34'(z_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff     <= z_in;
         sgn_ff   <= phase[31];
         hn_ff[0] <= '{z: z_ff, z2: zz[32:16], t: prpg_pkg::HORNER_SEED, sgn: sgn_ff};
      end
   end

   for (genvar j = 1; j <= 4; j++) begin : g_horner
      always_ff @(posedge clock) begin
         if (en) begin
            hn_ff[j] <= prpg_pkg::horner_step(hn_ff[j-1], prpg_pkg::HORNER_COEF[j-1]);
         end
      end
   end

   assign zt = 34'(hn_ff[4].z) * 34'(hn_ff[4].t);
   assign v  = zt[33:16] + 18'd2;
   assign s  = (v[17:2] > 16'd16384) ? 16'd16384 : v[17:2];
   assign pr = 32'(u_ff) * 32'(amplitude);

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff     <= hn_ff[4].sgn ? (16'd16384 - s) : (16'd16384 + s);
         texel_ff <= (pr[31:22] > 10'd255) ? 8'd255 : pr[29:22];
      end
   end

   assign texel = texel_ff;

endmodule

[sv/prpg_grad.sv]
module prpg_grad (
   input  logic                       clock,
   input  logic                       en,
   input  logic [prpg_pkg::PIX_W-1:0] pix_x,
   input  logic [prpg_pkg::PIX_W-1:0] pix_y,
   input  logic [prpg_pkg::DIM_W-1:0] width,
   input  logic [prpg_pkg::DIM_W-1:0] height,
   input  prpg_pkg::mode_type         mode,
   output logic [7:0]                 texel
);

   logic [24:0]      xh_ff, yw_ff, wh_ff;
   logic [25:0]      wh;
   logic [19:0]      x255_ff, y255_ff;
   logic [12:0]      w_ff, h_ff;
   logic [25:0]      sumxy;
   logic [32:0]      num;
   logic [24:0]      den;
   prpg_pkg::gd_type gd_ff [0:prpg_pkg::GD_STAGES];

   assign wh = 26'(width) * 26'(height);

   always_ff @(posedge clock) begin
      if (en) begin
         xh_ff   <= 25'(pix_x) * 25'(height);
         yw_ff   <= 25'(pix_y) * 25'(width);
         wh_ff   <= wh[24:0];
         x255_ff <= {pix_x, 8'd0} - {8'd0, pix_x};
         y255_ff <= {pix_y, 8'd0} - {8'd0, pix_y};
         w_ff    <= width;
         h_ff    <= height;
      end
   end

   assign sumxy = 26'(xh_ff) + 26'(yw_ff);

   always_comb begin
      unique case (mode)
         prpg_pkg::MODE_HORZ: begin
            num = 33'(x255_ff);
            den = 25'(w_ff);
         end
         prpg_pkg::MODE_VERT: begin
            num = 33'(y255_ff);
            den = 25'(h_ff);
         end
         default: begin
            num = {sumxy, 7'd0} - 33'(sumxy);
            den = wh_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gd_ff[0] <= '{rem: num, den: den, q: '0, sat: num >= {den, 8'd0}};
      end
   end

   for (genvar j = 1; j <= prpg_pkg::GD_STAGES; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            gd_ff[j] <= prpg_pkg::grad_step(prpg_pkg::grad_step(gd_ff[j-1], 9 - 2 * j),
                                            8 - 2 * j);
         end
      end
   end

   assign texel = gd_ff[prpg_pkg::GD_STAGES].sat ? 8'd255 : gd_ff[prpg_pkg::GD_STAGES].q;

endmodule

[sv/plasma_ring_pixel_generator.sv]
// Texel generator: one pixel coordinate in, one 8-bit texel out.
// Request channel: req_valid / req_stall with req_pix_x and req_pix_y.
// Response channel: rsp_valid / rsp_stall with rsp_texel; a word moves at a
// clock edge where valid is high and stall is low.
// Configuration: csr_wr_en, csr_index and csr_wr_data write one register per
// cycle; write only while no word is in flight. A mode above diagonal is ignored.
// The path from request to response is equally long for every mode: the stages of
// radius (squares, sum, two root bits per stage), of sine phase (product,
// two quotient bits per stage of a 52-bit division), of quarter-wave sine
// and amplitude, and the response register. Shorter paths are delayed to match.
// Throughput is one word per cycle. The whole pipeline moves as one: while a
// response sits stalled in the output register, every stage holds and
// req_stall is high; nothing is dropped or repeated.
// Synchronous reset clears all valid bits and restores the register defaults.
`include "plasma_ring_pixel_generator_assert.svh"

module plasma_ring_pixel_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [prpg_pkg::PIX_W-1:0]          req_pix_x,
   input  logic [prpg_pkg::PIX_W-1:0]          req_pix_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [prpg_pkg::TEXEL_W-1:0]        rsp_texel,
   input  logic                                csr_wr_en,
   input  logic [prpg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [prpg_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int PIPE_LAT  = prpg_pkg::PIPE_LAT;
   localparam int SHARP_DLY = PIPE_LAT - prpg_pkg::RAD_LAT - prpg_pkg::SHARP_LAT;
   localparam int GRAD_DLY  = PIPE_LAT - prpg_pkg::GRAD_LAT;

   prpg_pkg::mode_type            mode_ff;
   logic [prpg_pkg::DIM_W-1:0]    width_ff, height_ff;
   logic [15:0]                   start_ff, gain_ff, amp_ff, divisor_ff;
   logic [prpg_pkg::DIM_W-1:0]    w_cl, h_cl;
   logic [15:0]                   div_eff;

   logic                          en;
   logic [PIPE_LAT-1:0]           vld_ff;
   logic                          rsp_valid_ff;
   logic [7:0]                    rsp_texel_ff;

   logic [21:0]                   radius;
   logic [31:0]                   phase;
   logic [7:0]                    smooth_tx, grad_tx;
   logic signed [25:0]            sharp_t_in;
   logic signed [25:0]            sharp_t_ff;
   logic [40:0]                   sharp_pr;
   logic [7:0]                    sharp_tx_ff;
   logic [7:0]                    sharp_dly_ff [0:SHARP_DLY-1];
   logic [7:0]                    grad_dly_ff  [0:GRAD_DLY-1];
   logic [7:0]                    texel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= prpg_pkg::MODE_SMOOTH;
         width_ff   <= prpg_pkg::RST_WIDTH;
         height_ff  <= prpg_pkg::RST_HEIGHT;
         start_ff   <= prpg_pkg::RST_START;
         gain_ff    <= prpg_pkg::RST_GAIN;
         amp_ff     <= prpg_pkg::RST_AMPLITUDE;
         divisor_ff <= prpg_pkg::RST_DIVISOR;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            prpg_pkg::CSR_MODE: begin
               if (csr_wr_data[2:0] <= prpg_pkg::MODE_DIAG) begin
                  mode_ff <= prpg_pkg::mode_type'(csr_wr_data[2:0]);
               end
            end
            prpg_pkg::CSR_WIDTH:     width_ff   <= csr_wr_data[12:0];
            prpg_pkg::CSR_HEIGHT:    height_ff  <= csr_wr_data[12:0];
            prpg_pkg::CSR_START:     start_ff   <= csr_wr_data;
            prpg_pkg::CSR_GAIN:      gain_ff    <= csr_wr_data;
            prpg_pkg::CSR_AMPLITUDE: amp_ff     <= csr_wr_data;
            prpg_pkg::CSR_DIVISOR:   divisor_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign w_cl    = prpg_pkg::clamp_dim(width_ff);
   assign h_cl    = prpg_pkg::clamp_dim(height_ff);
   assign div_eff = (divisor_ff == '0) ? 16'd1 : divisor_ff;

   // freeze every stage while the response is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[PIPE_LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   prpg_radius u_radius (
      .clock  (clock),
      .en     (en),
      .pix_x  (req_pix_x),
      .pix_y  (req_pix_y),
      .width  (w_cl),
      .height (h_cl),
      .start  (start_ff),
      .radius (radius)
   );

   prpg_phase u_phase (
      .clock   (clock),
      .en      (en),
      .radius  (radius),
      .divisor (div_eff),
      .phase   (phase)
   );

   prpg_sine u_sine (
      .clock     (clock),
      .en        (en),
      .phase     (phase),
      .amplitude (amp_ff),
      .texel     (smooth_tx)
   );

   prpg_grad u_grad (
      .clock  (clock),
      .en     (en),
      .pix_x  (req_pix_x),
      .pix_y  (req_pix_y),
      .width  (w_cl),
      .height (h_cl),
      .mode   (mode_ff),
      .texel  (grad_tx)
   );

   // sharp rings: (start + r - 4) scaled by the ring gain
   assign sharp_t_in = $signed({2'b00, start_ff, 8'd0}) + $signed({4'd0, radius})
                     - 26'sd1024;
   assign sharp_pr   = 41'(sharp_t_ff[24:0]) * 41'(gain_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sharp_t_ff <= sharp_t_in;
         if (sharp_t_ff <= 26'sd0) begin
            sharp_tx_ff <= 8'd0;
         end else begin
            sharp_tx_ff <= (sharp_pr[40:20] > 21'd255) ? 8'd255 : sharp_pr[27:20];
         end
         sharp_dly_ff[0] <= sharp_tx_ff;
         for (int i = 1; i < SHARP_DLY; i++) sharp_dly_ff[i] <= sharp_dly_ff[i-1];
         grad_dly_ff[0] <= grad_tx;
         for (int i = 1; i < GRAD_DLY; i++) grad_dly_ff[i] <= grad_dly_ff[i-1];
      end
   end

   always_comb begin
      unique case (mode_ff)
         prpg_pkg::MODE_SMOOTH: texel_in = smooth_tx;
         prpg_pkg::MODE_SHARP:  texel_in = sharp_dly_ff[SHARP_DLY-1];
         default:               texel_in = grad_dly_ff[GRAD_DLY-1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_texel_ff <= texel_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_texel = rsp_texel_ff;

   `PRPG_ASSERT_NXT(a_deliver, clock, reset, vld_ff[PIPE_LAT-1] && !req_stall, rsp_valid_ff)
   `PRPG_ASSERT_NXT(a_drain, clock, reset, !vld_ff[PIPE_LAT-1] && !req_stall, !rsp_valid_ff)
   `PRPG_ASSERT_NXT(a_freeze, clock, reset, req_stall, $stable(vld_ff))
   `PRPG_ASSERT_IMP(a_stall_src, clock, reset, req_stall, rsp_valid_ff)

endmodule

[bench/plasma_ring_pixel_generator_tb.sv]
module plasma_ring_pixel_generator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAIL_CYCLES  = prpg_pkg::PIPE_LAT + 10;
   localparam int STALL_LIMIT  = 5000;
   localparam int PHASES       = 15;
   localparam int PER_PHASE    = 60;
   localparam longint unsigned PHASE_STEP = 64'd683565276;

   typedef struct {
      bit               is_csr;
      logic [2:0]       idx;
      logic [15:0]      data;
      logic [11:0]      x;
      logic [11:0]      y;
      int               texel;   // -1: take the predicted value
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_pix_x;
   logic [11:0] req_pix_y;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_texel;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wr_data;

   prpg_pkg::mode_type cur_mode;
   logic [12:0] cur_width;
   logic [12:0] cur_height;
   logic [15:0] cur_start;
   logic [15:0] cur_gain;
   logic [15:0] cur_amp;
   logic [15:0] cur_div;

   int          typed_texels[$];
   logic [7:0]  pending_texels[$];
   dir_row_type dir_rows[$];
   int          errors;
   int          checked;
   int          mode_hits[5];
   int          quiet_cycles;
   int          gap_pct;
   int          stall_pct;

   plasma_ring_pixel_generator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pix_x(req_pix_x), .req_pix_y(req_pix_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_texel(rsp_texel),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint unsigned sat_texel(input longint unsigned v);
      return (v > 255) ? 64'd255 : v;
   endfunction

   function automatic longint unsigned fit_dim(input logic [12:0] v);
      if (v == 0) return 1;
      if (v > 4096) return 4096;
      return v;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned quarter_wave(input longint unsigned z);
      longint unsigned z2, t;
      z2 = (z * z) >> 16;
      t = 11;
      t = 307 - ((z2 * t) >> 16);
      t = 5223 - ((z2 * t) >> 16);
      t = 42334 - ((z2 * t) >> 16);
      t = 102944 - ((z2 * t) >> 16);
      t = (((z * t) >> 16) + 2) >> 2;
      return (t > 16384) ? 64'd16384 : t;
   endfunction

   function automatic logic [7:0] predict_texel(input logic [11:0] px, input logic [11:0] py);
      longint unsigned w, h, x, y, sq, mag, prod, q, f, z, s, v, dv;
      longint          dx, dy, d, sv, t;
      logic [31:0]     ph;
      x = px;
      y = py;
      w = fit_dim(cur_width);
      h = fit_dim(cur_height);
      dx = 2 * longint'(x) - longint'(w);
      dy = 2 * longint'(y) - longint'(h);
      sq = 4 * longint'(cur_start) + longint'(dx * dx) + longint'(dy * dy);
      d = longint'(int_root(sq << 14)) - 1024;
      case (cur_mode)
         prpg_pkg::MODE_SMOOTH: begin
            dv = (cur_div == 0) ? 64'd1 : longint'(cur_div);
            mag = (d < 0) ? longint'(-d) : longint'(d);
            prod = mag * PHASE_STEP;
            q = prod / dv;
            if (d < 0 && (prod % dv) != 0) q = q + 1;
            ph = (d < 0) ? 32'(64'd0 - q) : 32'(q);
            f = (longint'(ph) >> 14) & 64'hFFFF;
            z = ph[30] ? (65536 - f) : f;
            s = quarter_wave(z);
            sv = ph[31] ? -longint'(s) : longint'(s);
            v = sat_texel((longint'(sv + 16384) * longint'(cur_amp)) >> 22);
         end
         prpg_pkg::MODE_SHARP: begin
            t = longint'(cur_start) * 256 + d;
            v = (t <= 0) ? 64'd0 : sat_texel((longint'(t) * longint'(cur_gain)) >> 20);
         end
         prpg_pkg::MODE_HORZ: v = sat_texel(x * 255 / w);
         prpg_pkg::MODE_VERT: v = sat_texel(y * 255 / h);
         default:             v = sat_texel((127 * x * h + 127 * y * w) / (w * h));
      endcase
      return v[7:0];
   endfunction

   // model registers follow the write port, scoreboard follows both channels
   always @(posedge clock) begin
      int tag;
      logic [7:0] want;
      if (reset) begin
         cur_mode   <= prpg_pkg::MODE_SMOOTH;
         cur_width  <= 13'd256;
         cur_height <= 13'd256;
         cur_start  <= 16'd16;
         cur_gain   <= 16'd4915;
         cur_amp    <= 16'd23040;
         cur_div    <= 16'd4096;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               prpg_pkg::CSR_MODE:      if (csr_wr_data[2:0] <= prpg_pkg::MODE_DIAG)
                                           cur_mode <= prpg_pkg::mode_type'(csr_wr_data[2:0]);
               prpg_pkg::CSR_WIDTH:     cur_width <= csr_wr_data[12:0];
               prpg_pkg::CSR_HEIGHT:    cur_height <= csr_wr_data[12:0];
               prpg_pkg::CSR_START:     cur_start <= csr_wr_data;
               prpg_pkg::CSR_GAIN:      cur_gain <= csr_wr_data;
               prpg_pkg::CSR_AMPLITUDE: cur_amp <= csr_wr_data;
               prpg_pkg::CSR_DIVISOR:   cur_div <= csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            tag = typed_texels.pop_front();
            want = predict_texel(req_pix_x, req_pix_y);
            pending_texels.push_back((tag >= 0) ? tag[7:0] : want);
            mode_hits[cur_mode]++;
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (pending_texels.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none actual %0d", $time, rsp_texel);
            end else begin
               want = pending_texels.pop_front();
               if (rsp_texel !== want) begin
                  errors++;
                  $display("%0t: texel mismatch, expected %0d actual %0d",
                           $time, want, rsp_texel);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("plasma_ring_pixel_generator verification failed");
            $finish;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < stall_pct);
   end

   task automatic drain();
      while (pending_texels.size() != 0 || typed_texels.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      drain();
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // drive one word; valid is low during a random gap, then raised, and lowered once the word is taken
   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input int texel);
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      typed_texels.push_back(texel);
      req_valid = 1'b1;
      req_pix_x = x;
      req_pix_y = y;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic logic [11:0] pick_coord(input logic [12:0] dim);
      longint unsigned lim;
      lim = fit_dim(dim);
      if ($urandom_range(9) == 0) return 12'($urandom);
      return 12'($urandom_range(int'(lim) - 1));
   endfunction

   function automatic logic [15:0] pick_dim();
      if ($urandom_range(7) == 0) return 16'($urandom_range(8191));
      if ($urandom_range(3) == 0) return 16'($urandom_range(1, 64));
      return 16'($urandom_range(1, 4096));
   endfunction

   initial begin
      logic [15:0] regs[7];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pix_x   = '0;
      req_pix_y   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = prpg_pkg::CSR_MODE;
      csr_wr_data = '0;
      errors      = 0;
      checked     = 0;
      quiet_cycles = 0;
      gap_pct     = 0;
      stall_pct   = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd128, 12'd128, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_MODE, 16'(prpg_pkg::MODE_HORZ), 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd0, 12'd0, 0});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd255, 12'd0, 254});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd4095, 12'd0, 255});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd128, 12'd17, 127});
      dir_rows.push_back('{1, prpg_pkg::CSR_WIDTH, 16'd0, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd0, 12'd0, 0});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd1, 12'd0, 255});
      dir_rows.push_back('{1, prpg_pkg::CSR_WIDTH, 16'd8191, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd4095, 12'd0, 254});
      // out-of-range mode is dropped, horizontal stays
      dir_rows.push_back('{1, prpg_pkg::CSR_MODE, 16'd7, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd4095, 12'd5, 254});
      dir_rows.push_back('{1, prpg_pkg::CSR_MODE, 16'(prpg_pkg::MODE_VERT), 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd0, 12'd255, 254});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd0, 12'd4095, 255});
      dir_rows.push_back('{1, prpg_pkg::CSR_MODE, 16'(prpg_pkg::MODE_DIAG), 12'd0, 12'd0, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_WIDTH, 16'd256, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd0, 12'd0, 0});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd4095, 12'd4095, 255});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd255, 12'd100, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_MODE, 16'(prpg_pkg::MODE_SHARP), 12'd0, 12'd0, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_START, 16'd0, 12'd0, 12'd0, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_GAIN, 16'd0, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd4095, 12'd4095, 0});
      dir_rows.push_back('{1, prpg_pkg::CSR_GAIN, 16'd65535, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd128, 12'd128, 0});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd4095, 12'd4095, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_MODE, 16'(prpg_pkg::MODE_SMOOTH), 12'd0, 12'd0, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_DIVISOR, 16'd0, 12'd0, 12'd0, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_AMPLITUDE, 16'd65535, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd7, 12'd200, -1});
      dir_rows.push_back('{1, prpg_pkg::CSR_AMPLITUDE, 16'd0, 12'd0, 12'd0, -1});
      dir_rows.push_back('{0, prpg_pkg::CSR_MODE, 16'd0, 12'd5, 12'd5, 0});

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) write_csr(dir_rows[i].idx, dir_rows[i].data);
         else send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].texel);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph == 0) begin
            regs = '{16'(prpg_pkg::MODE_SMOOTH), 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1};
         end else if (ph == 1) begin
            regs = '{16'(prpg_pkg::MODE_SHARP), 16'd4096, 16'd4096, 16'd65535, 16'd65535,
                     16'd65535, 16'd65535};
         end else begin
            regs[prpg_pkg::CSR_MODE]      = 16'(ph % 5);
            regs[prpg_pkg::CSR_WIDTH]     = pick_dim();
            regs[prpg_pkg::CSR_HEIGHT]    = pick_dim();
            regs[prpg_pkg::CSR_START]     = ($urandom_range(3) == 0) ? 16'($urandom) :
                                                                        16'($urandom_range(64));
            regs[prpg_pkg::CSR_GAIN]      = 16'($urandom);
            regs[prpg_pkg::CSR_AMPLITUDE] = 16'($urandom);
            regs[prpg_pkg::CSR_DIVISOR]   = ($urandom_range(1) == 0) ? 16'($urandom) :
                                                                   16'($urandom_range(256, 8192));
         end
         for (int r = 0; r < 7; r++) write_csr(3'(r), regs[r]);
         if ($urandom_range(2) == 0) write_csr(prpg_pkg::CSR_MODE, 16'($urandom_range(5, 7)));
         gap_pct   = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 6 : 49) : 0;
         stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 6 : 49) : 0;
         for (int k = 0; k < PER_PHASE; k++) begin
            // in phase 3 only, hold until the pipeline is empty once mid-phase
            if (ph == 3 && k == PER_PHASE / 2) drain();
            send_pixel(pick_coord(cur_width), pick_coord(cur_height), -1);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Checked %0d texels: smooth %0d, sharp %0d, horizontal %0d,",
               checked, mode_hits[0], mode_hits[1], mode_hits[2]);
      $display("vertical %0d, diagonal %0d; register extremes, clamped sizes, off-texture pixels.",
               mode_hits[3], mode_hits[4]);
      if (errors == 0 && pending_texels.size() == 0)
         $display("plasma_ring_pixel_generator verification clean");
      else
         $display("plasma_ring_pixel_generator verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/prpg_pkg.sv
sv/prpg_radius.sv
sv/prpg_phase.sv
sv/prpg_sine.sv
sv/prpg_grad.sv
sv/plasma_ring_pixel_generator.sv
bench/plasma_ring_pixel_generator_tb.sv
